/* rtl/core/tmq_pkg.sv */
// shared types and codes for the timer expiry queue
`default_nettype none

package tmq_pkg;

	localparam int REQ_TYPE_W = 2;
	localparam int TIMER_ID_W = 4;
	localparam int DELAY_W    = 16;

	localparam logic [REQ_TYPE_W-1:0] REQ_ARM    = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_CANCEL = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_TICK   = 2'd2;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [TIMER_ID_W-1:0] timer_id;
		logic [DELAY_W-1:0]    delay;
	} req_beat_t;

	typedef struct packed {
		logic [TIMER_ID_W-1:0] expired_id;
		logic                  last_expired;
	} exp_beat_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ARM,
		OP_CANCEL,
		OP_LOAD,
		OP_SORT,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [TIMER_ID_W-1:0] timer_id;
	} cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/tmq_cell.sv */
// one timer slot of the sorting chain: holds an entry and swaps or shifts with its neighbors
`default_nettype none

module tmq_cell import tmq_pkg::*; #(
	parameter int ID_W     = 4,
	parameter int TIME_W   = 32,
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_cmd_t         cmd,
	input  logic [TIME_W-1:0] now,
	input  logic [TIME_W-1:0] arm_deadline,
	input  logic              swap_l,
	input  logic              swap_r,
	input  logic [ID_W-1:0]   l_id,
	input  logic              l_active,
	input  logic              l_reached,
	input  logic [TIME_W-1:0] l_age,
	input  logic [TIME_W-1:0] l_deadline,
	input  logic [ID_W-1:0]   r_id,
	input  logic              r_active,
	input  logic              r_reached,
	input  logic [TIME_W-1:0] r_age,
	input  logic [TIME_W-1:0] r_deadline,
	output logic [ID_W-1:0]   id,
	output logic              active,
	output logic              reached,
	output logic [TIME_W-1:0] age,
	output logic [TIME_W-1:0] deadline
);

	logic [ID_W-1:0]   id_q;
	logic              active_q;
	logic              reached_q;
	logic [TIME_W-1:0] age_q;
	logic [TIME_W-1:0] deadline_q;
	logic [TIME_W-1:0] age_nxt;
	logic              hit;

	assign age_nxt = now - deadline_q;
	assign hit     = (32'(id_q) == 32'(cmd.timer_id));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q      <= ID_W'(CELL_IDX);
			active_q  <= 1'b0;
			reached_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_ARM: begin
					if (hit) begin
						active_q <= 1'b1;
					end
				end
				OP_CANCEL: begin
					if (hit) begin
						active_q <= 1'b0;
					end
				end
				OP_LOAD: begin
					reached_q <= active_q & ~age_nxt[TIME_W-1];
				end
				OP_SORT: begin
					if (swap_l) begin
						id_q      <= l_id;
						active_q  <= l_active;
						reached_q <= l_reached;
					end else if (swap_r) begin
						id_q      <= r_id;
						active_q  <= r_active;
						reached_q <= r_reached;
					end
				end
				OP_ROTATE: begin
					id_q      <= r_id;
					active_q  <= r_active;
					reached_q <= r_reached;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ARM: begin
				if (hit) begin
					deadline_q <= arm_deadline;
				end
			end
			OP_LOAD: begin
				age_q <= age_nxt;
			end
			OP_SORT: begin
				if (swap_l) begin
					age_q      <= l_age;
					deadline_q <= l_deadline;
				end else if (swap_r) begin
					age_q      <= r_age;
					deadline_q <= r_deadline;
				end
			end
			OP_ROTATE: begin
				age_q      <= r_age;
				deadline_q <= r_deadline;
			end
			default: begin
			end
		endcase
	end

	assign id       = id_q;
	assign active   = active_q;
	assign reached  = reached_q;
	assign age      = age_q;
	assign deadline = deadline_q;

endmodule

`default_nettype wire

/* rtl/core/timer_expiry_queue_top.sv */
// top level of the timer expiry queue: request channel, cell chain, sequencer, result register
`default_nettype none

// Usage:
// Request beats on req (req_valid/req_stall) carry arm, cancel or tick.
// Result beats on exp (exp_valid/exp_stall) carry one expired slot each,
// earliest deadline first, ties to the lower slot, last_expired on the final one.
// A tick advances the time counter, then the chain of NUM_TIMERS cells
// loads each slot's age, runs an odd-even transposition sort between
// neighbors, and rotates expired slots out of the head one per cycle
// while the output register is free. Arm and cancel do not raise req_stall.
// A tick holds req_stall through the load, sort and emit steps, also while
// exp stalls.
// A tick with no expiry gives no beat. The head is taken only while the
// output register is free, so a stall on exp just holds the chain.
// Reset clears all slots, the time counter and the output register.
module timer_expiry_queue_top import tmq_pkg::*; #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      exp_valid,
	input  logic      exp_stall,
	output exp_beat_t exp
);

	localparam int ID_W  = $clog2(NUM_TIMERS);
	localparam int CNT_W = $clog2(NUM_TIMERS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_SORT,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 exp_valid_q;
	exp_beat_t            exp_q;

	cell_cmd_t            cmd;
	logic [TIME_BITS-1:0] arm_deadline;
	logic                 accept;
	logic                 out_free;
	logic                 head_go;

	logic [ID_W-1:0]      c_id       [NUM_TIMERS];
	logic                 c_active   [NUM_TIMERS];
	logic                 c_reached  [NUM_TIMERS];
	logic [TIME_BITS-1:0] c_age      [NUM_TIMERS];
	logic [TIME_BITS-1:0] c_deadline [NUM_TIMERS];
	logic                 pair_swap  [NUM_TIMERS-1];

	function automatic logic precedes(
		input logic                 a_reached,
		input logic [TIME_BITS-1:0] a_age,
		input logic [ID_W-1:0]      a_id,
		input logic                 b_reached,
		input logic [TIME_BITS-1:0] b_age,
		input logic [ID_W-1:0]      b_id
	);
		precedes = a_reached & (~b_reached | (a_age > b_age) |
			((a_age == b_age) & (a_id < b_id)));
	endfunction

	assign accept       = req_valid & ~req_stall;
	assign req_stall    = (state_q != S_IDLE);
	assign out_free     = ~exp_valid_q | ~exp_stall;
	assign head_go      = (state_q == S_EMIT) & c_reached[0] & out_free;
	assign arm_deadline = now_q + TIME_BITS'(req.delay);

	always_comb begin
		cmd.op       = OP_NONE;
		cmd.timer_id = req.timer_id;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_ARM:    cmd.op = OP_ARM;
						REQ_CANCEL: cmd.op = OP_CANCEL;
						default:    cmd.op = OP_NONE;
					endcase
				end
			end
			S_LOAD:  cmd.op = OP_LOAD;
			S_SORT:  cmd.op = OP_SORT;
			S_EMIT:  cmd.op = head_go ? OP_ROTATE : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	for (genvar i = 0; i < NUM_TIMERS - 1; i++) begin : g_pair
		assign pair_swap[i] = (state_q == S_SORT) && (cnt_q[0] == ((i % 2) == 1)) &&
			precedes(c_reached[i+1], c_age[i+1], c_id[i+1],
				c_reached[i], c_age[i], c_id[i]);
	end

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		logic                 sl;
		logic                 sr;
		logic [ID_W-1:0]      lid;
		logic                 lact;
		logic                 lrch;
		logic [TIME_BITS-1:0] lage;
		logic [TIME_BITS-1:0] ldl;
		logic [ID_W-1:0]      rid;
		logic                 ract;
		logic                 rrch;
		logic [TIME_BITS-1:0] rage;
		logic [TIME_BITS-1:0] rdl;

		if (i == 0) begin : g_first
			assign sl   = 1'b0;
			assign lid  = c_id[i];
			assign lact = c_active[i];
			assign lrch = c_reached[i];
			assign lage = c_age[i];
			assign ldl  = c_deadline[i];
		end else begin : g_mid_l
			assign sl   = pair_swap[i-1];
			assign lid  = c_id[i-1];
			assign lact = c_active[i-1];
			assign lrch = c_reached[i-1];
			assign lage = c_age[i-1];
			assign ldl  = c_deadline[i-1];
		end

		if (i == NUM_TIMERS - 1) begin : g_last
			// head wraps to the tail as a free slot
			assign sr   = 1'b0;
			assign rid  = c_id[0];
			assign ract = 1'b0;
			assign rrch = 1'b0;
			assign rage = c_age[0];
			assign rdl  = c_deadline[0];
		end else begin : g_mid_r
			assign sr   = pair_swap[i];
			assign rid  = c_id[i+1];
			assign ract = c_active[i+1];
			assign rrch = c_reached[i+1];
			assign rage = c_age[i+1];
			assign rdl  = c_deadline[i+1];
		end

		tmq_cell #(
			.ID_W     (ID_W),
			.TIME_W   (TIME_BITS),
			.CELL_IDX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.now          (now_q),
			.arm_deadline (arm_deadline),
			.swap_l       (sl),
			.swap_r       (sr),
			.l_id         (lid),
			.l_active     (lact),
			.l_reached    (lrch),
			.l_age        (lage),
			.l_deadline   (ldl),
			.r_id         (rid),
			.r_active     (ract),
			.r_reached    (rrch),
			.r_age        (rage),
			.r_deadline   (rdl),
			.id           (c_id[i]),
			.active       (c_active[i]),
			.reached      (c_reached[i]),
			.age          (c_age[i]),
			.deadline     (c_deadline[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			now_q       <= '0;
			exp_valid_q <= 1'b0;
			exp_q       <= '0;
		end else begin
			if (out_free && !head_go) begin
				exp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && req.req_type == REQ_TICK) begin
						now_q   <= now_q + TIME_BITS'(1);
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_SORT;
				end
				S_SORT: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NUM_TIMERS - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!c_reached[0]) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						exp_valid_q        <= 1'b1;
						exp_q.expired_id   <= TIMER_ID_W'(c_id[0]);
						exp_q.last_expired <= ~c_reached[1];
						if (!c_reached[1]) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign exp_valid = exp_valid_q;
	assign exp       = exp_q;

endmodule

`default_nettype wire
